// ===== src/assert_macros.svh =====
// Assertion macros used by the flight phase sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, held off while aresetn is low.
`define FPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Concurrent implication check, same clocking and reset.
`define FPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/fps_pkg.sv =====
// Types and constants of the flight phase sequencer.
`default_nettype none

package fps_pkg;

    localparam int ALT_W  = 21;
    localparam int ACC_W  = 16;
    localparam int OFF_W  = 17;
    localparam int TIM_W  = 16;
    localparam int GAIN_W = 16;
    localparam int VEL_W  = 32;
    localparam int STEP_W = 18;
    localparam int PH_W   = 3;
    localparam int THR_W  = ALT_W + 2;

    // Phase codes
    localparam logic [PH_W-1:0] PH_START    = 3'd0;
    localparam logic [PH_W-1:0] PH_ASCEND   = 3'd1;
    localparam logic [PH_W-1:0] PH_FREEFALL = 3'd2;
    localparam logic [PH_W-1:0] PH_GYRO     = 3'd3;
    localparam logic [PH_W-1:0] PH_LANDING  = 3'd4;
    localparam logic [PH_W-1:0] PH_IDLE     = 3'd5;

    // Register indexes (byte address = 4 * index)
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_GROUND   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ASCEND   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DROP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GYRO     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IMPACT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LAND     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FF_TMO   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_VEL_GAIN = 3'd7;

    // Velocity thresholds in mm/s
    localparam logic signed [VEL_W-1:0] VEL_ASCEND_MIN = 32'sd80;
    localparam logic signed [VEL_W-1:0] VEL_REST_LIM   = 32'sd500;

    typedef struct packed {
        logic signed [ALT_W-1:0] ground_altitude;
        logic [OFF_W-1:0]        ascend_offset;
        logic [OFF_W-1:0]        drop_offset;
        logic [OFF_W-1:0]        gyro_offset;
        logic [OFF_W-1:0]        impact_offset;
        logic [OFF_W-1:0]        land_offset;
        logic [TIM_W-1:0]        freefall_timeout;
        logic [GAIN_W-1:0]       velocity_gain;
    } fps_cfg_t;

    // Altitude compares against the configured thresholds
    typedef struct packed {
        logic above_ascend;
        logic above_drop;
        logic below_gyro;
        logic below_impact;
        logic below_land;
    } fps_flags_t;

    typedef struct packed {
        logic signed [ALT_W-1:0] peak_altitude;
        logic signed [VEL_W-1:0] vertical_velocity;
        logic                    release_pulse;
        logic                    phase_changed;
        logic [PH_W-1:0]         phase;
    } fps_result_t;

endpackage

`default_nettype wire

// ===== src/fps_cfg_regs.sv =====
// APB configuration register bank of the flight phase sequencer.
`default_nettype none

module fps_cfg_regs (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [4:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready,
    output fps_pkg::fps_cfg_t    cfg
);
    import fps_pkg::*;

    fps_cfg_t               cfg_reg;
    fps_cfg_t               cfg_next;
    logic                   wr_en;
    logic [REG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_GROUND:   cfg_next.ground_altitude  = $signed(pwdata[ALT_W-1:0]);
                REG_ASCEND:   cfg_next.ascend_offset    = pwdata[OFF_W-1:0];
                REG_DROP:     cfg_next.drop_offset      = pwdata[OFF_W-1:0];
                REG_GYRO:     cfg_next.gyro_offset      = pwdata[OFF_W-1:0];
                REG_IMPACT:   cfg_next.impact_offset    = pwdata[OFF_W-1:0];
                REG_LAND:     cfg_next.land_offset      = pwdata[OFF_W-1:0];
                REG_FF_TMO:   cfg_next.freefall_timeout = pwdata[TIM_W-1:0];
                REG_VEL_GAIN: cfg_next.velocity_gain    = pwdata[GAIN_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ground_altitude  <= '0;
            cfg_reg.ascend_offset    <= 17'd200;
            cfg_reg.drop_offset      <= 17'd39500;
            cfg_reg.gyro_offset      <= 17'd25500;
            cfg_reg.impact_offset    <= 17'd1000;
            cfg_reg.land_offset      <= 17'd200;
            cfg_reg.freefall_timeout <= 16'd60;
            cfg_reg.velocity_gain    <= 16'd31360;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux, raw register bits zero-extended
    always_comb begin
        unique case (reg_idx)
            REG_GROUND:   prdata = {11'b0, cfg_reg.ground_altitude};
            REG_ASCEND:   prdata = {15'b0, cfg_reg.ascend_offset};
            REG_DROP:     prdata = {15'b0, cfg_reg.drop_offset};
            REG_GYRO:     prdata = {15'b0, cfg_reg.gyro_offset};
            REG_IMPACT:   prdata = {15'b0, cfg_reg.impact_offset};
            REG_LAND:     prdata = {15'b0, cfg_reg.land_offset};
            REG_FF_TMO:   prdata = {16'b0, cfg_reg.freefall_timeout};
            REG_VEL_GAIN: prdata = {16'b0, cfg_reg.velocity_gain};
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/fps_phase_ctrl.sv =====
// Velocity accumulator, phase state machine and result register.
`default_nettype none

module fps_phase_ctrl #(
    parameter int IDLE_HOLD_SAMPLES = 50
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               en,
    input  wire logic signed [fps_pkg::ALT_W-1:0]   alt,
    input  wire logic signed [fps_pkg::STEP_W-1:0]  step,
    input  wire fps_pkg::fps_flags_t                flags,
    input  wire logic [fps_pkg::TIM_W-1:0]          freefall_timeout,
    output fps_pkg::fps_result_t                    result
);
    import fps_pkg::*;

    localparam logic [TIM_W-1:0] IDLE_HOLD = TIM_W'(IDLE_HOLD_SAMPLES);
    localparam logic [TIM_W-1:0] TIM_MAX   = '1;

    logic [PH_W-1:0]         phase_reg,   phase_next;
    logic signed [VEL_W-1:0] vel_reg,     vel_next;
    logic signed [ALT_W-1:0] run_peak_reg, run_peak_next;
    logic signed [ALT_W-1:0] lat_peak_reg, lat_peak_next;
    logic [TIM_W-1:0]        timer_reg,   timer_next;
    logic                    release_next;
    fps_result_t             result_reg;

    logic signed [VEL_W:0]   vel_sum;
    logic [TIM_W-1:0]        timer_inc;

    // Saturating velocity integration
    always_comb begin
        vel_sum = {vel_reg[VEL_W-1], vel_reg} + (VEL_W+1)'(step);
        if (vel_sum[VEL_W] != vel_sum[VEL_W-1]) begin
            vel_next = vel_sum[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            vel_next = vel_sum[VEL_W-1:0];
        end
    end

    assign timer_inc = (timer_reg == TIM_MAX) ? timer_reg : timer_reg + 1'b1;

    // Phase transitions, using the updated velocity
    always_comb begin
        phase_next    = phase_reg;
        run_peak_next = run_peak_reg;
        lat_peak_next = lat_peak_reg;
        timer_next    = timer_reg;
        release_next  = 1'b0;
        unique case (phase_reg)
            PH_ASCEND: begin
                if (alt > run_peak_reg) run_peak_next = alt;
                if (flags.above_drop && vel_next[VEL_W-1]) begin
                    phase_next    = PH_FREEFALL;
                    lat_peak_next = (alt > run_peak_reg) ? alt : run_peak_reg;
                    run_peak_next = '0;
                    timer_next    = '0;
                end
            end
            PH_FREEFALL: begin
                timer_next = timer_inc;
                if (flags.below_gyro || timer_inc > freefall_timeout) begin
                    phase_next   = PH_GYRO;
                    release_next = 1'b1;
                    timer_next   = '0;
                end
            end
            PH_GYRO: begin
                if (flags.below_impact) phase_next = PH_LANDING;
            end
            PH_LANDING: begin
                if (flags.below_land && vel_next > -VEL_REST_LIM
                        && vel_next < VEL_REST_LIM) begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                end
            end
            PH_IDLE: begin
                timer_next = timer_inc;
                if (timer_inc >= IDLE_HOLD) begin
                    phase_next = PH_START;
                    timer_next = '0;
                end
            end
            default: begin
                // start, and the two unused codes
                if (vel_next >= VEL_ASCEND_MIN && flags.above_ascend) phase_next = PH_ASCEND;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_START;
            vel_reg      <= '0;
            run_peak_reg <= '0;
            lat_peak_reg <= '0;
            timer_reg    <= '0;
        end else if (en) begin
            phase_reg    <= phase_next;
            vel_reg      <= vel_next;
            run_peak_reg <= run_peak_next;
            lat_peak_reg <= lat_peak_next;
            timer_reg    <= timer_next;
        end
    end

    // Result register, payload only
    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg.phase             <= phase_next;
            result_reg.phase_changed     <= (phase_next != phase_reg);
            result_reg.release_pulse     <= release_next;
            result_reg.vertical_velocity <= vel_next;
            result_reg.peak_altitude     <= lat_peak_next;
        end
    end

    assign result = result_reg;

`include "assert_macros.svh"

    `FPS_ASSERT_IMP(a_release_enters_gyro, en && release_next, phase_reg == PH_FREEFALL && phase_next == PH_GYRO, "release outside free fall exit")
    `FPS_ASSERT_IMP(a_idle_timer_bound, phase_reg == PH_IDLE, timer_reg < IDLE_HOLD, "idle hold counter overran")
    `FPS_ASSERT_IMP(a_peak_latch_source, $past(aresetn) && !$stable(lat_peak_reg), $past(phase_reg) == PH_ASCEND, "peak latched outside ascent")

endmodule

`default_nettype wire

// ===== src/flight_phase_sequencer.sv =====
// Flight phase sequencer top level: sample pipeline, config port and result channel.
//
// One transfer on s_ carries one sensor sample (altitude in cm, raw vertical
// acceleration); each sample yields exactly one result transfer on m_ carrying
// the phase after the sample, transition and release flags, the integrated
// vertical velocity in mm/s and the latched peak altitude.
// Pipeline: input register, gain multiply plus threshold compares, then the
// velocity accumulator and phase logic feeding the result register. m_tvalid
// rises once a sample has passed the input, stage 2 and result registers; one
// sample per cycle sustained while m_tready stays high.
// Each stage moves on whenever the stage after it is empty or moving, so a
// stalled receiver only holds the stages that are full; s_tready drops once
// all three are occupied and m_tready is low. No result is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline, returns the phase to start,
// clears velocity, peaks and timer, and loads the default thresholds. The user must
// write registers over the APB port only while no sample is in flight (unenforced).
`default_nettype none

module flight_phase_sequencer #(
    parameter int ONE_G_COUNTS      = 2048,
    parameter int IDLE_HOLD_SAMPLES = 50
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // s_tdata: [20:0] altitude_cm, [36:21] accel_vertical, [39:37] zero
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [39:0]  s_tdata,
    // m_tdata: [2:0] phase, [3] phase_changed, [4] release_pulse,
    //          [36:5] vertical_velocity, [57:37] peak_altitude, [63:58] zero
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import fps_pkg::*;

    localparam int DIFF_W = ACC_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam logic signed [DIFF_W-1:0] ONE_G = DIFF_W'(ONE_G_COUNTS);
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32768);

    fps_cfg_t    cfg;
    fps_flags_t  flags_next;
    fps_flags_t  s2_flags_reg;
    fps_result_t result;

    logic en1, en2, en3;
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;

    logic signed [ALT_W-1:0]  s1_alt_reg,   s2_alt_reg;
    logic signed [ACC_W-1:0]  s1_accel_reg;
    logic signed [STEP_W-1:0] s2_step_reg,  step_next;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [THR_W-1:0]  alt_x;
    logic signed [THR_W-1:0]  ground_x;
    logic signed [THR_W-1:0]  thr_ascend, thr_drop, thr_gyro, thr_impact, thr_land;

    // Stage enables: a stage loads when it is empty or its content moves on
    assign en3      = !out_valid_reg || m_tready;
    assign en2      = !s2_valid_reg  || en3;
    assign en1      = !s1_valid_reg  || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1) s1_valid_reg  <= s_tvalid;
            if (en2) s2_valid_reg  <= s1_valid_reg;
            if (en3) out_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: input register
    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            s1_alt_reg   <= $signed(s_tdata[ALT_W-1:0]);
            s1_accel_reg <= $signed(s_tdata[ALT_W+ACC_W-1:ALT_W]);
        end
    end

    // Velocity step: round half up of (1g - accel) * gain in Q16
    always_comb begin
        diff      = ONE_G - DIFF_W'(s1_accel_reg);
        prod      = PROD_W'(diff) * $signed({{(PROD_W-GAIN_W){1'b0}}, cfg.velocity_gain});
        prod_rnd  = prod + HALF_LSB;
        step_next = prod_rnd[PROD_W-1:16];
    end

    // Altitude against ground plus offsets, formed wide enough not to wrap
    always_comb begin
        alt_x      = THR_W'(s1_alt_reg);
        ground_x   = THR_W'(cfg.ground_altitude);
        thr_ascend = ground_x + $signed({6'b0, cfg.ascend_offset});
        thr_drop   = ground_x + $signed({6'b0, cfg.drop_offset});
        thr_gyro   = ground_x + $signed({6'b0, cfg.gyro_offset});
        thr_impact = ground_x + $signed({6'b0, cfg.impact_offset});
        thr_land   = ground_x + $signed({6'b0, cfg.land_offset});
        flags_next.above_ascend = alt_x > thr_ascend;
        flags_next.above_drop   = alt_x > thr_drop;
        flags_next.below_gyro   = alt_x < thr_gyro;
        flags_next.below_impact = alt_x < thr_impact;
        flags_next.below_land   = alt_x < thr_land;
    end

    // Stage 2 register
    always_ff @(posedge aclk) begin
        if (en2 && s1_valid_reg) begin
            s2_alt_reg   <= s1_alt_reg;
            s2_step_reg  <= step_next;
            s2_flags_reg <= flags_next;
        end
    end

    fps_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 3: state update and result register
    fps_phase_ctrl #(
        .IDLE_HOLD_SAMPLES (IDLE_HOLD_SAMPLES)
    ) u_phase (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en3 && s2_valid_reg),
        .alt              (s2_alt_reg),
        .step             (s2_step_reg),
        .flags            (s2_flags_reg),
        .freefall_timeout (cfg.freefall_timeout),
        .result           (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, result.peak_altitude, result.vertical_velocity,
                       result.release_pulse, result.phase_changed, result.phase};

endmodule

`default_nettype wire
